>>> rtl/zone_scan_people_counter_macros.svh
// Assertion macros for the assertion checker of the people counter.
`ifndef ZONE_SCAN_PEOPLE_COUNTER_MACROS_SVH
`define ZONE_SCAN_PEOPLE_COUNTER_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ZSPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ZSPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/zspc_pkg.sv
package zspc_pkg;

  // Field widths of the words on both channels.
  localparam int DIST_W  = 16;
  localparam int COUNT_W = 16;
  localparam int OCC_W   = 15;

  // Zone counters are sized for the largest supported frame of 16 zones.
  localparam int DEFAULT_MAX_ZONES = 16;
  localparam int ZONE_POS_W        = 5;
  localparam int ZONE_IDX_W        = 4;

  // Threshold value after reset.
  localparam logic [DIST_W-1:0] THRESH_RESET = 16'd1500;

  // Saturation limits of the signed room count.
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

  // Crossing reported with a frame's result.
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTRY = 2'd1,
    EV_EXIT  = 2'd2
  } crossing_ev_t;

  // Summary of a frame as seen at its final zone.
  typedef struct packed {
    logic                  person;
    logic                  first_person;
    logic                  best_found;
    logic [ZONE_IDX_W-1:0] best_zone;
    logic [ZONE_POS_W-1:0] size;
  } frame_sum_t;

  // One result word.
  typedef struct packed {
    logic [OCC_W-1:0]          occupancy;
    logic signed [COUNT_W-1:0] raw_count;
    crossing_ev_t              crossing_event;
    logic                      tracking;
  } count_res_t;

endpackage

>>> rtl/zspc_in_if.sv
interface zspc_in_if
  import zspc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic              last_zone;

  modport source (output valid, output distance, output last_zone, input ready);
  modport sink (input valid, input distance, input last_zone, output ready);
endinterface

>>> rtl/zspc_out_if.sv
interface zspc_out_if
  import zspc_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [OCC_W-1:0]          occupancy;
  logic signed [COUNT_W-1:0] raw_count;
  logic [1:0]                crossing_event;
  logic                      tracking;

  modport source (output valid, output occupancy, output raw_count,
                  output crossing_event, output tracking, input ready);
  modport sink (input valid, input occupancy, input raw_count,
                input crossing_event, input tracking, output ready);
endinterface

>>> rtl/zone_scan_people_counter.sv
// Bidirectional people counter for a multi-zone ranging sensor. Each input
// word is one zone's distance, with last_zone set on the frame's final zone;
// exactly one result word follows each frame, carrying the signed count, the
// occupancy clamped at zero, the crossing counted in that frame and the
// tracking flag. A zone holds a person when its distance is below
// presence_threshold, written through cfg_wr_en and cfg_wr_data; the user must
// write it only while idle, which the block itself does not enforce. The
// block takes one word per cycle, except that a stalled output blocks a
// final zone (other zones keep flowing): each word is held in an input
// register and processed into the frame registers, and the frame's result
// word is loaded into the output register as its final zone moves on.
module zone_scan_people_counter
  import zspc_pkg::*;
#(
  parameter int MAX_ZONES = DEFAULT_MAX_ZONES
) (
  input  logic              clk,
  input  logic              rst_n,
  zspc_in_if.sink           in_bus,
  zspc_out_if.source        out_bus,
  input  logic              cfg_wr_en,
  input  logic [DIST_W-1:0] cfg_wr_data
);

  logic              item_v_r;
  logic [DIST_W-1:0] item_dist_r;
  logic              item_last_r;
  logic [DIST_W-1:0] thresh_r;
  logic              out_v_r;
  count_res_t        out_res_r;
  logic              out_free;
  logic              advance;
  logic              frame_end;
  frame_sum_t        sum;
  count_res_t        res;

  // Handshake: a registered word moves on unless it ends a frame and the
  // result register is still full.
  assign out_free     = !out_v_r || out_bus.ready;
  assign advance      = item_v_r && (!item_last_r || out_free);
  assign frame_end    = advance && item_last_r;
  assign in_bus.ready = !item_v_r || advance;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      thresh_r <= cfg_wr_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_bus.ready) begin
      item_v_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      item_dist_r <= in_bus.distance;
      item_last_r <= in_bus.last_zone;
    end
  end

  zspc_frame_scan #(
    .MAX_ZONES (MAX_ZONES)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .distance  (item_dist_r),
    .last_zone (item_last_r),
    .threshold (thresh_r),
    .sum       (sum)
  );

  zspc_passage_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame_end (frame_end),
    .sum       (sum),
    .res       (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (frame_end) begin
      out_v_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_end) begin
      out_res_r <= res;
    end
  end

  assign out_bus.valid          = out_v_r;
  assign out_bus.occupancy      = out_res_r.occupancy;
  assign out_bus.raw_count      = out_res_r.raw_count;
  assign out_bus.crossing_event = out_res_r.crossing_event;
  assign out_bus.tracking       = out_res_r.tracking;

endmodule

>>> rtl/zspc_frame_scan.sv
module zspc_frame_scan
  import zspc_pkg::*;
#(
  parameter int MAX_ZONES = DEFAULT_MAX_ZONES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [DIST_W-1:0] distance,
  input  logic              last_zone,
  input  logic [DIST_W-1:0] threshold,
  output frame_sum_t        sum
);

  localparam logic [ZONE_POS_W-1:0] ZoneLimit = ZONE_POS_W'(MAX_ZONES);

  logic [ZONE_POS_W-1:0] pos_r, pos_nxt;
  logic [DIST_W-1:0]     best_dist_r, best_dist_nxt;
  logic [ZONE_IDX_W-1:0] best_zone_r, best_zone_nxt;
  logic                  best_found_r, best_found_nxt;
  logic                  first_person_r, first_person_nxt;
  logic                  person;

  // Per-zone update of the running frame summary.
  always_comb begin
    person           = distance < threshold;
    pos_nxt          = pos_r;
    best_dist_nxt    = best_dist_r;
    best_zone_nxt    = best_zone_r;
    best_found_nxt   = best_found_r;
    first_person_nxt = first_person_r;
    if (pos_r < ZoneLimit) begin
      if (pos_r == '0) begin
        first_person_nxt = person;
      end
      if (person && (distance > best_dist_r)) begin
        best_dist_nxt  = distance;
        best_zone_nxt  = pos_r[ZONE_IDX_W-1:0];
        best_found_nxt = 1'b1;
      end
      pos_nxt = pos_r + 1'b1;
    end
  end

  // The summary includes the zone being processed now.
  assign sum.person       = person;
  assign sum.first_person = first_person_nxt;
  assign sum.best_found   = best_found_nxt;
  assign sum.best_zone    = best_zone_nxt;
  assign sum.size         = pos_nxt;

  // Frame registers, cleared after the final zone.
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && last_zone)) begin
      pos_r          <= '0;
      best_dist_r    <= '0;
      best_zone_r    <= '0;
      best_found_r   <= 1'b0;
      first_person_r <= 1'b0;
    end else if (fire) begin
      pos_r          <= pos_nxt;
      best_dist_r    <= best_dist_nxt;
      best_zone_r    <= best_zone_nxt;
      best_found_r   <= best_found_nxt;
      first_person_r <= first_person_nxt;
    end
  end

endmodule

>>> rtl/zspc_passage_fsm.sv
module zspc_passage_fsm
  import zspc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       frame_end,
  input  frame_sum_t sum,
  output count_res_t res
);

  logic                      started_r, started_nxt;
  logic                      start_valid_r, start_valid_nxt;
  logic [ZONE_IDX_W-1:0]     start_zone_r, start_zone_nxt;
  logic                      done_r, done_nxt;
  logic signed [COUNT_W-1:0] count_r, count_nxt;
  crossing_ev_t              ev;
  logic [ZONE_POS_W-1:0]     half;
  logic                      low_start;

  // Passage tracking and counting at the end of a frame.
  always_comb begin
    half            = sum.size >> 1;
    low_start       = {1'b0, start_zone_r} < half;
    started_nxt     = started_r | sum.best_found;
    start_valid_nxt = start_valid_r;
    start_zone_nxt  = start_zone_r;
    done_nxt        = done_r;
    count_nxt       = count_r;
    ev              = EV_NONE;
    if (started_nxt) begin
      if (!start_valid_r) begin
        start_zone_nxt  = sum.best_zone;
        start_valid_nxt = sum.best_found;
      end else if (!done_r) begin
        if (low_start && sum.person) begin
          if (count_r != COUNT_MAX) begin
            count_nxt = count_r + 16'sd1;
          end
          done_nxt = 1'b1;
          ev       = EV_ENTRY;
        end else if (!low_start && sum.first_person) begin
          if (count_r != COUNT_MIN) begin
            count_nxt = count_r - 16'sd1;
          end
          done_nxt = 1'b1;
          ev       = EV_EXIT;
        end
      end else if (!sum.best_found) begin
        started_nxt     = 1'b0;
        done_nxt        = 1'b0;
        start_valid_nxt = 1'b0;
        start_zone_nxt  = '0;
      end
    end
  end

  // Result word built from the updated state.
  assign res.occupancy      = count_nxt[COUNT_W-1] ? '0 : count_nxt[OCC_W-1:0];
  assign res.raw_count      = count_nxt;
  assign res.crossing_event = ev;
  assign res.tracking       = started_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r     <= 1'b0;
      start_valid_r <= 1'b0;
      start_zone_r  <= '0;
      done_r        <= 1'b0;
      count_r       <= '0;
    end else if (frame_end) begin
      started_r     <= started_nxt;
      start_valid_r <= start_valid_nxt;
      start_zone_r  <= start_zone_nxt;
      done_r        <= done_nxt;
      count_r       <= count_nxt;
    end
  end

endmodule

>>> rtl/zspc_checker.sv
`include "zone_scan_people_counter_macros.svh"

module zspc_assert_checker
  import zspc_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [OCC_W-1:0]          out_occupancy,
  input logic signed [COUNT_W-1:0] out_raw_count,
  input logic [1:0]                out_crossing_event,
  input logic                      out_tracking
);

  // No result word is offered in the cycle after reset.
  `ZSPC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

  // A stalled result word holds its count.
  `ZSPC_ASSERT(a_stall_hold, clk, rst_n,
    out_valid && !out_ready |=> out_valid && $stable(out_raw_count) &&
    $stable(out_crossing_event), "stalled result changed")

  // Occupancy is the count clamped at zero.
  `ZSPC_ASSERT(a_occ_clamp, clk, rst_n,
    out_valid |-> (out_raw_count[COUNT_W-1] ? (out_occupancy == '0) :
    (out_occupancy == out_raw_count[OCC_W-1:0])), "occupancy does not match count")

  // A counted crossing belongs to a tracked passage and has a known code.
  `ZSPC_ASSERT(a_event_tracked, clk, rst_n,
    out_valid && (out_crossing_event != EV_NONE) |-> out_tracking &&
    (out_crossing_event != 2'd3), "crossing without tracking")

endmodule

bind zone_scan_people_counter zspc_assert_checker u_zspc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_bus.valid),
  .out_ready          (out_bus.ready),
  .out_occupancy      (out_bus.occupancy),
  .out_raw_count      (out_bus.raw_count),
  .out_crossing_event (out_bus.crossing_event),
  .out_tracking       (out_bus.tracking)
);

>>> test/zspc_checker.sv
// Watches both channels of the people counter, predicts the result word of
// every frame and compares it with what the block delivers.
module zspc_checker
  import zspc_pkg::*;
#(
  parameter int MAX_ZONES = DEFAULT_MAX_ZONES
) (
  input  logic              clk,
  input  logic              rst_n,
  zspc_in_if                in_mon,
  zspc_out_if               out_mon,
  input  logic              cfg_wr_en,
  input  logic [DIST_W-1:0] cfg_wr_data,
  output int                fail_count,
  output int                results_left
);

  // Own copy of the threshold and of the frame and passage state.
  logic [DIST_W-1:0]         threshold;
  logic [ZONE_POS_W-1:0]     zone_pos;
  logic [DIST_W-1:0]         best_dist;
  logic [ZONE_POS_W-1:0]     best_zone;
  logic                      best_found;
  logic                      first_person;
  logic                      tracking;
  logic                      start_valid;
  logic [ZONE_POS_W-1:0]     start_zone;
  logic                      crossed;
  logic signed [COUNT_W-1:0] room_count;

  // Result words still owed by the block, oldest first.
  count_res_t frame_results_q[$];
  count_res_t want;
  int         errors = 0;

  function automatic void clear_frame_scan();
    zone_pos     = '0;
    best_dist    = '0;
    best_zone    = '0;
    best_found   = 1'b0;
    first_person = 1'b0;
  endfunction

  // Folds one zone word into the frame scan; on the final zone it runs the
  // passage state machine and queues the frame's result word.
  function automatic void count_zone(logic [DIST_W-1:0] d, logic last);
    logic         person;
    int unsigned  size;
    crossing_ev_t ev;
    count_res_t   res;
    person = d < threshold;
    ev = EV_NONE;
    // Zones past the largest frame are left out of the search.
    if (zone_pos < MAX_ZONES) begin
      if (zone_pos == 0) first_person = person;
      if (person && d > best_dist) begin
        best_dist  = d;
        best_zone  = zone_pos;
        best_found = 1'b1;
      end
      zone_pos = zone_pos + 1'b1;
    end
    if (last) begin
      size = (zone_pos == 0) ? 1 : int'(zone_pos);
      if (best_found) tracking = 1'b1;
      if (tracking) begin
        if (!start_valid) begin
          start_zone  = best_zone;
          start_valid = best_found;
        end else if (!crossed) begin
          // Started in the near half and now at the far end: an entry.
          if (start_zone < size / 2 && person) begin
            if (room_count != COUNT_MAX) room_count = room_count + 16'sd1;
            crossed = 1'b1;
            ev = EV_ENTRY;
          end else if (start_zone >= size / 2 && first_person) begin
            if (room_count != COUNT_MIN) room_count = room_count - 16'sd1;
            crossed = 1'b1;
            ev = EV_EXIT;
          end
        end else if (!best_found) begin
          // An empty frame after a crossing ends the passage.
          tracking    = 1'b0;
          crossed     = 1'b0;
          start_valid = 1'b0;
          start_zone  = '0;
        end
      end
      res.occupancy      = room_count[COUNT_W-1] ? '0 : room_count[OCC_W-1:0];
      res.raw_count      = room_count;
      res.crossing_event = ev;
      res.tracking       = tracking;
      frame_results_q.push_back(res);
      clear_frame_scan();
    end
  endfunction

  // The result side is checked before the zone word of the same edge is
  // absorbed, since a result can never belong to a word taken that edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      threshold   = THRESH_RESET;
      tracking    = 1'b0;
      start_valid = 1'b0;
      start_zone  = '0;
      crossed     = 1'b0;
      room_count  = '0;
      clear_frame_scan();
      frame_results_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (frame_results_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result word: occ %0d raw %0d event %0d tracking %0d",
                     out_mon.occupancy, out_mon.raw_count, out_mon.crossing_event,
                     out_mon.tracking);
        end else begin
          want = frame_results_q.pop_front();
          if (out_mon.occupancy !== want.occupancy ||
              out_mon.raw_count !== want.raw_count ||
              out_mon.crossing_event !== want.crossing_event ||
              out_mon.tracking !== want.tracking) begin
            errors++;
            if (errors <= 10)
              $display({"result word mismatch: expected occ %0d raw %0d event %0d ",
                        "tracking %0d, got occ %0d raw %0d event %0d tracking %0d"},
                       want.occupancy, $signed(want.raw_count), want.crossing_event,
                       want.tracking, out_mon.occupancy, $signed(out_mon.raw_count),
                       out_mon.crossing_event, out_mon.tracking);
          end
        end
      end
      if (cfg_wr_en) threshold = cfg_wr_data;
      if (in_mon.valid && in_mon.ready) count_zone(in_mon.distance, in_mon.last_zone);
    end
    fail_count   <= errors;
    results_left <= frame_results_q.size();
  end

endmodule

>>> test/testbench.sv
// Stimulus and verdict for the people counter; the checker beside the
// block does all prediction and comparison.
module testbench;
  import zspc_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [DIST_W-1:0] cfg_wr_data;
  int                fail_count;
  int                results_left;

  // Threshold in force, used to shape distances that hold or miss a person.
  int thr = 1500;
  int burst_left = 0;
  bit gaps_on = 1'b0;
  int stall_pct = 0;
  int stall_left = 0;
  int zones_sent = 0;

  zspc_in_if  in_bus ();
  zspc_out_if out_bus ();

  zone_scan_people_counter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  zspc_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fail_count   (fail_count),
    .results_left (results_left)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: mostly ready, with stalls of random length at a set rate.
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(0, 9);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Distance of a zone that holds a person, and of one that does not.
  function automatic logic [DIST_W-1:0] near_dist();
    if (thr == 0) return DIST_W'($urandom);
    return DIST_W'($urandom_range(thr - 1, 0));
  endfunction

  function automatic logic [DIST_W-1:0] far_dist();
    return DIST_W'($urandom_range(65535, thr));
  endfunction

  // Sends one zone word in bursts with random gaps between them.
  task automatic send_zone(logic [DIST_W-1:0] d, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_bus.valid     <= 1'b1;
    in_bus.distance  <= d;
    in_bus.last_zone <= last;
    do @(posedge clk); while (!in_bus.ready);
    zones_sent++;
  endtask

  // Frame of n zones with a person over zones lo to lo+w-1.
  task automatic send_frame(int n, int lo, int w);
    for (int i = 0; i < n; i++)
      send_zone((i >= lo && i < lo + w) ? near_dist() : far_dist(), i == n - 1);
  endtask

  // A person walking across the zones, one frame per step; frames below
  // steps cut the passage short.
  task automatic walk(int n, bit to_exit, int steps, int frames);
    int p, w, lo;
    for (int s = 0; s < frames; s++) begin
      p = s * (n - 1) / (steps - 1);
      if (to_exit) p = n - 1 - p;
      w = $urandom_range(1, 3);
      if (w > n) w = n;
      lo = (p + w > n) ? n - w : p;
      send_frame(n, lo, w);
    end
  endtask

  // Holds the sender until every owed result word has come back. The first
  // edge lets the owed count take in the word accepted just before.
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (results_left != 0) @(posedge clk);
  endtask

  // Threshold writes only happen with the block drained and quiet.
  task automatic set_threshold(int v);
    drain();
    repeat (6) @(posedge clk);
    cfg_wr_data <= DIST_W'(v);
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    thr = v;
  endtask

  // Random frames, mostly well-formed passages with random content.
  task automatic run_traffic(int zone_budget);
    int stop_at, n, r, steps, k;
    bit dir;
    stop_at = zones_sent + zone_budget;
    while (zones_sent < stop_at) begin
      r = $urandom_range(99);
      n = ($urandom_range(3) == 0) ? $urandom_range(2, 6)
                                   : $urandom_range(2, DEFAULT_MAX_ZONES);
      steps = $urandom_range(2, 5);
      dir = 1'($urandom_range(1));
      if (r < 60) begin
        walk(n, dir, steps, steps);
        repeat ($urandom_range(0, 2)) send_frame(n, 0, 0);
      end else if (r < 72) begin
        // Passage abandoned halfway, sometimes turning back.
        k = $urandom_range(1, steps - 1);
        walk(n, dir, steps, k);
        if ($urandom_range(1)) walk(n, !dir, steps, steps);
      end else if (r < 84) begin
        for (int i = 0; i < n; i++) send_zone(DIST_W'($urandom), i == n - 1);
      end else if (r < 90) begin
        send_frame($urandom_range(17, 20), $urandom_range(0, 19), $urandom_range(0, 3));
      end else if (r < 96) begin
        send_frame(1, 0, $urandom_range(1));
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    int v;
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.distance  <= '0;
    in_bus.last_zone <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames at the reset threshold.
    // Equal distances: the earlier zone wins and is latched as start.
    send_zone(16'd800, 1'b0);
    send_zone(16'd800, 1'b0);
    send_zone(16'd2000, 1'b1);
    // Zero distance counts as a person at the final zone but never as best.
    send_zone(16'd1500, 1'b0);
    send_zone(16'd0, 1'b1);
    send_zone(16'd65535, 1'b1);
    // Single-zone frames: only the exit test can fire.
    send_zone(16'd1499, 1'b1);
    send_zone(16'd0, 1'b1);
    send_zone(16'd1500, 1'b1);
    // Start in zone 0, then an overlong frame whose flagged final zone
    // still decides the entry test.
    send_zone(16'd1, 1'b1);
    for (int i = 0; i < 17; i++)
      send_zone((i == 16) ? 16'd1400 : ((i == 15) ? 16'd900 : 16'd40000), i == 16);

    // Random traffic over several thresholds, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: v = 1500;
        1: v = 65535;
        2: v = 0;
        3: v = $urandom_range(200, 60000);
        4: v = 1;
        default: v = $urandom_range(1000, 3000);
      endcase
      set_threshold(v);
      gaps_on = (ph != 0);
      stall_pct = (ph == 0) ? 0 : $urandom_range(10, 60);
      run_traffic(300);
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && results_left == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #30000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/zspc_pkg.sv
rtl/zspc_in_if.sv
rtl/zspc_out_if.sv
rtl/zspc_frame_scan.sv
rtl/zspc_passage_fsm.sv
rtl/zone_scan_people_counter.sv
rtl/zspc_checker.sv
test/zspc_checker.sv
test/testbench.sv
